@@ src/ket_pkg.sv @@
// Shared types and constants for the key matrix edge tracker.
// No dependencies; ket_row_step and the top level refer to this package.
package ket_pkg;

    localparam int RowW         = 3;
    localparam int ColW         = 17;
    localparam int RowsDefault  = 6;
    localparam int ColsDefault  = 17;

    // Per-key tracker state, two bits each
    typedef enum logic [1:0] {
        KEY_IDLE      = 2'd0,
        KEY_JUST      = 2'd1,
        KEY_HELD      = 2'd2,
        KEY_RELEASING = 2'd3
    } t_key_state;

    typedef struct packed {
        logic [RowW-1:0] row_number;
        logic [ColW-1:0] column_bits;
    } t_in_item;

    typedef struct packed {
        logic [RowW-1:0] row_echo;
        logic [ColW-1:0] just_pressed_mask;
        logic [ColW-1:0] held_mask;
        logic [ColW-1:0] releasing_mask;
    } t_out_item;

endpackage

@@ src/ket_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per handshake.
// The payload type is given by the instantiating scope (see ket_pkg).
interface ket_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ket_row_step.sv @@
// Steps every key tracker of one row and derives the state masks.
// Depends on ket_pkg for the tracker state encoding.
module ket_row_step #(
    parameter int NCOLS = ket_pkg::ColsDefault
) (
    input  ket_pkg::t_key_state [NCOLS-1:0] i_cur,
    input  logic [NCOLS-1:0]                i_keys,
    input  logic                            i_release_mode,
    output ket_pkg::t_key_state [NCOLS-1:0] o_next,
    output logic [NCOLS-1:0]                o_just,
    output logic [NCOLS-1:0]                o_held,
    output logic [NCOLS-1:0]                o_releasing
);

    always_comb begin
        for (int c = 0; c < NCOLS; c++) begin
            unique case (i_cur[c])
                ket_pkg::KEY_IDLE: begin
                    o_next[c] = i_keys[c] ? ket_pkg::KEY_JUST : ket_pkg::KEY_IDLE;
                end
                ket_pkg::KEY_JUST: begin
                    o_next[c] = i_keys[c] ? ket_pkg::KEY_HELD : ket_pkg::KEY_IDLE;
                end
                ket_pkg::KEY_HELD: begin
                    o_next[c] = i_keys[c] ? ket_pkg::KEY_HELD : ket_pkg::KEY_RELEASING;
                end
                ket_pkg::KEY_RELEASING: begin
                    // mode 1 always drops back to idle
                    if (i_release_mode || !i_keys[c]) begin
                        o_next[c] = ket_pkg::KEY_IDLE;
                    end else begin
                        o_next[c] = ket_pkg::KEY_RELEASING;
                    end
                end
                default: begin
                    o_next[c] = ket_pkg::KEY_IDLE;
                end
            endcase
            o_just[c]      = (o_next[c] == ket_pkg::KEY_JUST);
            o_held[c]      = (o_next[c] == ket_pkg::KEY_HELD);
            o_releasing[c] = (o_next[c] == ket_pkg::KEY_RELEASING);
        end
    end

endmodule

@@ src/key_matrix_edge_tracker.sv @@
// Top level of the key matrix edge tracker: input register, tracker store,
// result register. Depends on ket_pkg, ket_stream_if and ket_row_step.
//
// Usage:
//   i_in carries one sampled row (row_number, column_bits). o_out returns
//   one result per item: the row echoed plus the just-pressed, held and
//   releasing masks of that row, read after its trackers were stepped.
//   i_cfg_we / i_cfg_wdata write release_mode (0: releasing waits for key
//   up, 1: releasing always returns to idle); write it only while idle.
// Path: an accepted item is held in the input register; its result is
//   loaded into the result register when the item advances and shows on o_out.
// Throughput: one item per cycle while o_out is not stalled. The row read,
//   the per-key step of all columns and the row write-back happen in the
//   cycle in which the item moves from the input register to the result
//   register, so items for the same row follow each other without a hazard.
// Rows at or above ROWS change no state and return all-zero masks.
// Reset (synchronous, active low): all trackers idle, release_mode 0,
//   both registers empty.
// Stall: while o_out.ready is low the result holds; the input register
//   still takes one more item, then i_in.ready drops until the result
//   is taken.
module key_matrix_edge_tracker #(
    parameter int ROWS = ket_pkg::RowsDefault,
    parameter int COLS = ket_pkg::ColsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ket_stream_if.sink           i_in,
    ket_stream_if.source         o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);

    // Columns past the port width read as open and stay idle: no storage
    localparam int TrackCols = (COLS < ket_pkg::ColW) ? COLS : ket_pkg::ColW;
    localparam int RowIdxW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Configuration
    logic r_release_mode;

    // Input register
    logic              r_in_valid;
    ket_pkg::t_in_item r_in;

    // Result register
    logic               r_out_valid;
    ket_pkg::t_out_item r_out;
    ket_pkg::t_out_item n_out;

    // Tracker store: one row of key states per matrix row
    ket_pkg::t_key_state [ROWS-1:0][TrackCols-1:0] r_track;

    logic                                w_accept;
    logic                                w_advance;
    logic [31:0]                         w_row_ext;
    logic                                w_in_range;
    logic [RowIdxW-1:0]                  w_idx;
    ket_pkg::t_key_state [TrackCols-1:0] w_cur;
    ket_pkg::t_key_state [TrackCols-1:0] w_next;
    logic [TrackCols-1:0]                w_just;
    logic [TrackCols-1:0]                w_held;
    logic [TrackCols-1:0]                w_rel;

    // Handshakes: advance moves the held item into the result register
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Row decode
    assign w_row_ext  = 32'(r_in.row_number);
    assign w_in_range = (w_row_ext < 32'(ROWS));
    assign w_idx      = w_row_ext[RowIdxW-1:0];
    assign w_cur      = r_track[w_idx];

    ket_row_step #(
        .NCOLS (TrackCols)
    ) u_step (
        .i_cur          (w_cur),
        .i_keys         (r_in.column_bits[TrackCols-1:0]),
        .i_release_mode (r_release_mode),
        .o_next         (w_next),
        .o_just         (w_just),
        .o_held         (w_held),
        .o_releasing    (w_rel)
    );

    // Build the result; out-of-range rows report nothing
    always_comb begin
        n_out.row_echo = r_in.row_number;
        if (w_in_range) begin
            n_out.just_pressed_mask = ket_pkg::ColW'(w_just);
            n_out.held_mask         = ket_pkg::ColW'(w_held);
            n_out.releasing_mask    = ket_pkg::ColW'(w_rel);
        end else begin
            n_out.just_pressed_mask = '0;
            n_out.held_mask         = '0;
            n_out.releasing_mask    = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_release_mode <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_release_mode <= i_cfg_wdata;
            end
        end
    end

    // Tracker store: clear on reset, write back the stepped row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < TrackCols; c++) begin
                    r_track[r][c] <= ket_pkg::KEY_IDLE;
                end
            end
        end else if (w_advance && w_in_range) begin
            r_track[w_idx] <= w_next;
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in.data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // A key is in exactly one state, so the masks never overlap
    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.just_pressed_mask & r_out.held_mask) == '0 &&
                         (r_out.just_pressed_mask & r_out.releasing_mask) == '0 &&
                         (r_out.held_mask & r_out.releasing_mask) == '0))
        else $error("state masks overlap");

    // Rows outside the matrix report empty masks
    a_out_of_range_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (32'(r_out.row_echo) >= 32'(ROWS))) |->
        (r_out.just_pressed_mask == '0 && r_out.held_mask == '0 &&
         r_out.releasing_mask == '0))
        else $error("out-of-range row reported keys");

    // Trackers change only when an item advances
    a_track_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_track))
        else $error("tracker store changed without an item");

    // An advancing item always lands in the result register
    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result lost after advance");

    // Never accept while a held item cannot move on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input register overrun");

endmodule
